// ----- sv/tcc_pkg.sv -----
// Package with the shared types, byte constants and bound checks of the charset classifier.
`default_nettype none

package tcc_pkg;

   localparam logic [7:0] BYTE_ESC     = 8'h1b;
   localparam logic [7:0] BYTE_C1_LAST = 8'h9f;

   localparam int unsigned MASK_ESCAPE = 0;
   localparam int unsigned MASK_HIGH   = 1;
   localparam int unsigned MASK_C1     = 2;
   localparam int unsigned MASK_UTF8   = 3;

   typedef enum logic [1:0] {
      CLASS_UNKNOWN = 2'd0,
      CLASS_ASCII   = 2'd1,
      CLASS_UTF8    = 2'd2
   } charset_type;

   typedef enum logic [2:0] {
      BOUND_ANY = 3'd0,
      BOUND_E0  = 3'd1,
      BOUND_ED  = 3'd2,
      BOUND_F0  = 3'd3,
      BOUND_F4  = 3'd4
   } bound_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } byte_beat_type;

   typedef struct packed {
      logic [3:0]  attribute_mask;
      charset_type charset_class;
   } result_type;

   function automatic logic cont_in_bounds(input logic [7:0] b, input bound_kind_type kind);
      logic ok;
      case (kind)
         BOUND_E0: ok = (b >= 8'ha0) && (b <= 8'hbf);
         BOUND_ED: ok = (b >= 8'h80) && (b <= 8'h9f);
         BOUND_F0: ok = (b >= 8'h90) && (b <= 8'hbf);
         BOUND_F4: ok = (b >= 8'h80) && (b <= 8'h8f);
         default:  ok = (b >= 8'h80) && (b <= 8'hbf);
      endcase
      return ok;
   endfunction

endpackage

`default_nettype wire

// ----- sv/tcc_in_reg.sv -----
// Input register that holds one request beat until the core takes it.
`default_nettype none

module tcc_in_reg
   import tcc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire byte_beat_type req_beat,
   input  wire logic          take,
   output logic               beat_valid,
   output byte_beat_type      beat
);

   logic          valid_ff;
   logic          valid_in;
   byte_beat_type beat_ff;

   assign req_ready  = !valid_ff || take;
   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         beat_ff <= req_beat;
      end
   end

endmodule

`default_nettype wire

// ----- sv/tcc_core.sv -----
// Flag tracking and strict UTF-8 validation state, updated once per byte.
`default_nettype none

module tcc_core
   import tcc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          take,
   input  wire byte_beat_type beat,
   output result_type         result
);

   logic           escape_ff, escape_in;
   logic           high_ff, high_in;
   logic           c1_ff, c1_in;
   logic           valid_ff, valid_in;
   logic [1:0]     left_ff, left_in;
   bound_kind_type kind_ff, kind_in;
   logic [7:0]     b;

   assign b = beat.data_byte;

   always_comb begin
      escape_in = escape_ff;
      high_in   = high_ff;
      c1_in     = c1_ff;
      valid_in  = valid_ff;
      left_in   = left_ff;
      kind_in   = kind_ff;

      if (b == BYTE_ESC) begin
         escape_in = 1'b1;
      end else if (b[7]) begin
         high_in = 1'b1;
         if (b <= BYTE_C1_LAST) begin
            c1_in = 1'b1;
         end
      end

      if (valid_ff) begin
         if (left_ff != 2'd0) begin
            if (cont_in_bounds(b, kind_ff)) begin
               left_in = left_ff - 2'd1;
               kind_in = BOUND_ANY;
            end else begin
               valid_in = 1'b0;
               left_in  = 2'd0;
               kind_in  = BOUND_ANY;
            end
         end else if (b[7]) begin
            if (b >= 8'hc2 && b <= 8'hdf) begin
               left_in = 2'd1;
               kind_in = BOUND_ANY;
            end else if (b == 8'he0) begin
               left_in = 2'd2;
               kind_in = BOUND_E0;
            end else if (b == 8'hed) begin
               left_in = 2'd2;
               kind_in = BOUND_ED;
            end else if (b >= 8'he1 && b <= 8'hef) begin
               left_in = 2'd2;
               kind_in = BOUND_ANY;
            end else if (b == 8'hf0) begin
               left_in = 2'd3;
               kind_in = BOUND_F0;
            end else if (b >= 8'hf1 && b <= 8'hf3) begin
               left_in = 2'd3;
               kind_in = BOUND_ANY;
            end else if (b == 8'hf4) begin
               left_in = 2'd3;
               kind_in = BOUND_F4;
            end else begin
               valid_in = 1'b0;
               left_in  = 2'd0;
               kind_in  = BOUND_ANY;
            end
         end
      end
   end

   always_comb begin
      result.attribute_mask            = '0;
      result.attribute_mask[MASK_ESCAPE] = escape_in;
      result.attribute_mask[MASK_HIGH]   = high_in;
      result.attribute_mask[MASK_C1]     = c1_in;
      result.attribute_mask[MASK_UTF8]   = high_in && valid_in;
      if (!high_in) begin
         result.charset_class = CLASS_ASCII;
      end else if (valid_in) begin
         result.charset_class = CLASS_UTF8;
      end else begin
         result.charset_class = CLASS_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && beat.end_of_file)) begin
         escape_ff <= 1'b0;
         high_ff   <= 1'b0;
         c1_ff     <= 1'b0;
         valid_ff  <= 1'b1;
         left_ff   <= 2'd0;
         kind_ff   <= BOUND_ANY;
      end else if (take) begin
         escape_ff <= escape_in;
         high_ff   <= high_in;
         c1_ff     <= c1_in;
         valid_ff  <= valid_in;
         left_ff   <= left_in;
         kind_ff   <= kind_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/tcc_out_reg.sv -----
// Result register that holds one response beat until it is taken.
`default_nettype none

module tcc_out_reg
   import tcc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type result,
   output logic            room,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output result_type      rsp_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign room       = !valid_ff || rsp_ready;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule

`default_nettype wire

// ----- sv/text_charset_classifier.sv -----
// Top level of the text charset classifier.
`default_nettype none

// The block classifies a file streamed in one byte per beat, with the last byte marked by
// req_end_of_file. It takes one byte every cycle unless a final byte waits for room in
// the result register; a byte passes an input register, then the flag and UTF-8 state
// update, and the marked last byte yields one response beat, held in the result register.
// A stalled response side thus holds back input only at file ends.
// Reset is synchronous and active high and puts the block in its start-of-file state.
module text_charset_classifier
   import tcc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_file,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_attribute_mask,
   output logic [1:0]      rsp_charset_class
);

   byte_beat_type req_beat;
   byte_beat_type beat;
   logic          beat_valid;
   logic          take;
   logic          room;
   result_type    result;
   result_type    rsp_result;

   assign req_beat.data_byte   = req_data_byte;
   assign req_beat.end_of_file = req_end_of_file;

   assign take = beat_valid && (!beat.end_of_file || room);

   tcc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_beat   (req_beat),
      .take       (take),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   tcc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .beat   (beat),
      .result (result)
   );

   tcc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (take && beat.end_of_file),
      .result     (result),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_attribute_mask = rsp_result.attribute_mask;
   assign rsp_charset_class  = rsp_result.charset_class;

endmodule

`default_nettype wire

// ----- sv/tcc_checker.sv -----
// Port-level checker for the text charset classifier and its bind statement.
`default_nettype none

module tcc_checker
   import tcc_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_data_byte,
   input wire logic       req_end_of_file,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] rsp_attribute_mask,
   input wire logic [1:0] rsp_charset_class
);

   logic unused_req;

   assign unused_req = req_valid ^ (^req_data_byte) ^ req_end_of_file;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_attribute_mask)
         && $stable(rsp_charset_class))
      else $error("Stalled response beat changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_attribute_mask[MASK_UTF8] == (rsp_charset_class == CLASS_UTF8))
         && (rsp_attribute_mask[MASK_HIGH] == (rsp_charset_class != CLASS_ASCII)))
      else $error("Charset class disagrees with attribute mask.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_attribute_mask[MASK_C1] |-> rsp_attribute_mask[MASK_HIGH]
         && (rsp_charset_class != CLASS_ASCII))
      else $error("C1 control flagged without a high-bit byte.");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("Block not idle after reset.");

endmodule

bind text_charset_classifier tcc_checker u_tcc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_data_byte      (req_data_byte),
   .req_end_of_file    (req_end_of_file),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_attribute_mask (rsp_attribute_mask),
   .rsp_charset_class  (rsp_charset_class)
);

`default_nettype wire
